/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL files that include them.
// Each macro samples on clk and is muted while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Escape tracking mode
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESCAPE = 3'd1,
		MODE_HEX1   = 3'd2,
		MODE_HEX2   = 3'd3,
		MODE_HEX3   = 3'd4,
		MODE_HEX4   = 3'd5
	} mode_t;

	// Character codes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	// One output word, without the last mark
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       error_flag;
	} result_t;

	// Up to three words caused by one input byte
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
		result_t    r2;
	} group_t;

	// Hex digit value; anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (ch >= 8'h30 && ch <= 8'h39) begin
				d = ch - 8'h30;
			end else if (ch >= 8'h41 && ch <= 8'h46) begin
				d = ch - 8'h37;
			end else if (ch >= 8'h61 && ch <= 8'h66) begin
				d = ch - 8'h57;
			end
			return d[3:0];
		end
	endfunction

endpackage

/* rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one input byte: escape mode, \u code
// gathering and UTF-8 encoding of the finished code.
// ----------------------------------------------------------------------------
module jsu_decode
	import jsu_pkg::*;
(
	input  mode_t       mode,
	input  logic [15:0] accum,
	input  logic [7:0]  char_byte,
	input  logic        stream_end,
	output mode_t       nxt_mode,
	output logic [15:0] nxt_accum,
	output group_t      grp
);

	logic [15:0] code;

	// Shift the next hex digit into the code
	assign code = {accum[11:0], hex_value(char_byte)};

	always_comb begin
		nxt_mode = mode;
		nxt_accum = accum;
		grp = '0;
		if (stream_end) begin
			// Input ended inside the string: flag and reset
			nxt_mode = MODE_NORMAL;
			nxt_accum = 16'h0000;
			grp.count = 2'd1;
			grp.r0.error_flag = 1'b1;
		end else begin
			unique case (mode)
				MODE_ESCAPE: begin
					nxt_mode = MODE_NORMAL;
					grp.count = 2'd1;
					grp.r0.byte_valid = 1'b1;
					unique case (char_byte)
						CH_QUOTE:  grp.r0.out_byte = CH_QUOTE;
						CH_BSLASH: grp.r0.out_byte = CH_BSLASH;
						CH_SLASH:  grp.r0.out_byte = CH_SLASH;
						CH_B:      grp.r0.out_byte = CTL_BS;
						CH_F:      grp.r0.out_byte = CTL_FF;
						CH_N:      grp.r0.out_byte = CTL_LF;
						CH_R:      grp.r0.out_byte = CTL_CR;
						CH_T:      grp.r0.out_byte = CTL_TAB;
						CH_U: begin
							nxt_mode = MODE_HEX1;
							nxt_accum = 16'h0000;
							grp = '0;
						end
						default: begin
							// Unknown escape: drop it
							grp = '0;
						end
					endcase
				end
				MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
					nxt_accum = code;
					nxt_mode = mode_t'(mode + 3'd1);
				end
				MODE_HEX4: begin
					nxt_mode = MODE_NORMAL;
					nxt_accum = 16'h0000;
					// Encode the code as UTF-8
					grp.r0.byte_valid = 1'b1;
					if (code[15:7] == 9'd0) begin
						grp.count = 2'd1;
						grp.r0.out_byte = code[7:0];
					end else if (code[15:11] == 5'd0) begin
						grp.count = 2'd2;
						grp.r0.out_byte = {3'b110, code[10:6]};
						grp.r1.out_byte = {2'b10, code[5:0]};
						grp.r1.byte_valid = 1'b1;
					end else begin
						grp.count = 2'd3;
						grp.r0.out_byte = {4'b1110, code[15:12]};
						grp.r1.out_byte = {2'b10, code[11:6]};
						grp.r1.byte_valid = 1'b1;
						grp.r2.out_byte = {2'b10, code[5:0]};
						grp.r2.byte_valid = 1'b1;
					end
				end
				default: begin
					// Normal text
					nxt_mode = MODE_NORMAL;
					if (char_byte == CH_BSLASH) begin
						nxt_mode = MODE_ESCAPE;
					end else if (char_byte == CH_QUOTE) begin
						nxt_accum = 16'h0000;
						grp.count = 2'd1;
						grp.r0.string_end = 1'b1;
					end else begin
						grp.count = 2'd1;
						grp.r0.out_byte = char_byte;
						grp.r0.byte_valid = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes the body of a JSON string literal into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one raw byte per word, char_byte, or
//   stream_end high to report that the input ran out inside the string.
//   Output channel (out_valid/out_ready): one word per result, out_byte with
//   byte_valid, string_end on the closing quote, error_flag on early end,
//   and last on the final word caused by an input byte.
//   Results are registered and appear in the cycle after the input word is accepted.
//   Throughput: one input byte per cycle while each byte yields at most one
//   word and out_ready is high; a \u escape yielding two or three UTF-8 bytes
//   holds the input while the output register drains one word per cycle
//   with out_ready high. Bytes that yield nothing (backslash, u, the first
//   three hex digits) are taken at one per cycle without touching the output.
//   in_ready stays high while the output register is empty or its final
//   word is being taken in the same cycle.
//   Reset: normal text mode, code cleared, output register empty.
//   Receiver stall: the pending word holds, and the input stalls until the
//   final word of its group is taken.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_end,
	output logic       error_flag,
	output logic       last
);

`include "assert_macros.svh"

	mode_t       mode_q;
	logic [15:0] accum_q;
	mode_t       nxt_mode;
	logic [15:0] nxt_accum;
	group_t      grp;
	result_t     r0_s1, r1_s1, r2_s1;
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;
	result_t     cur;
	logic        in_acc, out_acc, grp_done;

	jsu_decode u_decode (
		.mode       (mode_q),
		.accum      (accum_q),
		.char_byte  (char_byte),
		.stream_end (stream_end),
		.nxt_mode   (nxt_mode),
		.nxt_accum  (nxt_accum),
		.grp        (grp)
	);

	// Handshakes
	assign out_valid = (cnt_q != 2'd0);
	assign last = out_valid && (idx_q == cnt_q - 2'd1);
	assign grp_done = out_ready && last;
	assign in_ready = !out_valid || grp_done;
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Select the current word of the group
	always_comb begin
		unique case (idx_q)
			2'd0:    cur = r0_s1;
			2'd1:    cur = r1_s1;
			default: cur = r2_s1;
		endcase
	end

	assign out_byte = cur.out_byte;
	assign byte_valid = cur.byte_valid;
	assign string_end = cur.string_end;
	assign error_flag = cur.error_flag;

	// Advance escape state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			accum_q <= 16'h0000;
		end else if (in_acc) begin
			mode_q <= nxt_mode;
			accum_q <= nxt_accum;
		end
	end

	// Track the output group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (in_acc) begin
			cnt_q <= grp.count;
			idx_q <= 2'd0;
		end else if (out_acc) begin
			if (last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			r0_s1 <= grp.r0;
			r1_s1 <= grp.r1;
			r2_s1 <= grp.r2;
		end
	end

	`ASSERT_IMPL(a_idx_in_group, cnt_q != 2'd0, idx_q < cnt_q, "word index beyond group")
	`ASSERT_IMPL(a_ready_only_when_free, in_ready && out_valid, out_ready && last,
		"input taken while group still pending")
	`ASSERT_IMPL(a_flags_final, out_valid && (string_end || error_flag), last && !byte_valid,
		"end or error word not final")
	`ASSERT_NEXT(a_end_resets, in_valid && in_ready && stream_end,
		mode_q == MODE_NORMAL && accum_q == 16'h0000 && cnt_q == 2'd1 && error_flag,
		"early end did not reset state")

endmodule

/* test/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string unescaper.
// A stimulus table covers the byte extremes, quotes, escapes, \u codes of two
// and three UTF-8 bytes and early end of input. Random string fragments
// follow. Each accepted byte is run through a local unescaper, and its output
// words, or the words the table gives, are queued. Every output word is checked
// field by field against that queue while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PRINT_LIMIT = 100;

	// One output word as seen on the ports
	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       closed;
		logic       broken;
		logic       tail;
	} word_t;

	// One row of the stimulus table
	typedef struct packed {
		logic [7:0]  ch;
		logic        eos;
		bit          typed;
		int unsigned n;
		word_t       w;
	} row_t;

	localparam word_t W_NONE = '0;
	localparam word_t W_QUOTE = {8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
	localparam word_t W_ERR = {8'h00, 1'b0, 1'b0, 1'b1, 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_byte = 8'h00;
	logic       stream_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_end;
	logic       error_flag;
	logic       last;

	// Local copy of the unescaper state
	mode_t       esc_mode = MODE_NORMAL;
	logic [15:0] code_acc = 16'h0000;

	word_t       step_words[$];
	word_t       pending_words[$];
	word_t       typed_words[$];
	bit          typed_row = 1'b0;
	row_t        directed_bytes[$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned words_checked = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	json_string_unescape_utf8 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.stream_end(stream_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.string_end(string_end),
		.error_flag(error_flag),
		.last      (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles,
				pending_words.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("word %0d: %s", words_checked, msg);
	endtask

	function automatic word_t data_word(input logic [7:0] b, input logic tail);
		return {b, 1'b1, 1'b0, 1'b0, tail};
	endfunction

	// Append one word to the words caused by the current byte
	function automatic void add_step(input word_t w);
		step_words.insert(step_words.size(), w);
	endfunction

	// Hex digit value, zero for anything that is not a hex digit
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c[3:0];
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return c[3:0] + 4'd9;
		return 4'h0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return "0" + nib;
		return (upper ? "A" : "a") + nib - 8'd10;
	endfunction

	// Advance the local unescaper by one input byte; fill step_words
	task automatic unescape_step(input logic [7:0] ch, input logic eos);
		logic [15:0] uc;
		step_words.delete();
		if (eos) begin
			esc_mode = MODE_NORMAL;
			code_acc = 16'h0000;
			add_step(W_ERR);
		end else begin
			case (esc_mode)
				MODE_ESCAPE: begin
					esc_mode = MODE_NORMAL;
					case (ch)
						CH_QUOTE, CH_BSLASH, CH_SLASH: add_step(data_word(ch, 1'b1));
						CH_B: add_step(data_word(CTL_BS, 1'b1));
						CH_F: add_step(data_word(CTL_FF, 1'b1));
						CH_N: add_step(data_word(CTL_LF, 1'b1));
						CH_R: add_step(data_word(CTL_CR, 1'b1));
						CH_T: add_step(data_word(CTL_TAB, 1'b1));
						CH_U: begin
							esc_mode = MODE_HEX1;
							code_acc = 16'h0000;
						end
						// unknown escape: drop the byte
						default: ;
					endcase
				end
				MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
					code_acc = {code_acc[11:0], hex_digit(ch)};
					if (esc_mode != MODE_HEX4) begin
						esc_mode = mode_t'(esc_mode + 3'd1);
					end else begin
						uc = code_acc;
						esc_mode = MODE_NORMAL;
						code_acc = 16'h0000;
						if (uc <= 16'h007F) begin
							add_step(data_word(uc[7:0], 1'b1));
						end else if (uc <= 16'h07FF) begin
							add_step(data_word({3'b110, uc[10:6]}, 1'b0));
							add_step(data_word({2'b10, uc[5:0]}, 1'b1));
						end else begin
							add_step(data_word({4'b1110, uc[15:12]}, 1'b0));
							add_step(data_word({2'b10, uc[11:6]}, 1'b0));
							add_step(data_word({2'b10, uc[5:0]}, 1'b1));
						end
					end
				end
				// normal text, unused codes too
				default: begin
					esc_mode = MODE_NORMAL;
					if (ch == CH_BSLASH) begin
						esc_mode = MODE_ESCAPE;
					end else if (ch == CH_QUOTE) begin
						code_acc = 16'h0000;
						add_step(W_QUOTE);
					end else begin
						add_step(data_word(ch, 1'b1));
					end
				end
			endcase
		end
	endtask

	// Offer one byte, hold it until taken, then queue what it causes
	task automatic send_byte(input logic [7:0] ch, input logic eos);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= ch;
		stream_end <= eos;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		unescape_step(ch, eos);
		if (typed_row) begin
			foreach (typed_words[i]) pending_words.insert(pending_words.size(), typed_words[i]);
		end else begin
			foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
		end
	endtask

	// Drop valid and hold off until every queued word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	function automatic void add_row(input logic [7:0] ch, input logic eos, input bit typed,
		input int unsigned n, input word_t w);
		row_t r;
		r.ch = ch;
		r.eos = eos;
		r.typed = typed;
		r.n = n;
		r.w = w;
		directed_bytes.insert(directed_bytes.size(), r);
	endfunction

	// Send one random string fragment, mostly well formed
	task automatic send_random_piece();
		int unsigned kind;
		int unsigned k;
		logic [15:0] cp;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 38) begin
			b = 8'($urandom_range(255));
			if (b == CH_BSLASH || b == CH_QUOTE)
				b = b ^ 8'h01;
			send_byte(b, 1'b0);
		end else if (kind < 60) begin
			send_byte(CH_BSLASH, 1'b0);
			case ($urandom_range(7))
				0: b = CH_QUOTE;
				1: b = CH_BSLASH;
				2: b = CH_SLASH;
				3: b = CH_B;
				4: b = CH_F;
				5: b = CH_N;
				6: b = CH_R;
				default: b = CH_T;
			endcase
			send_byte(b, 1'b0);
		end else if (kind < 78) begin
			case ($urandom_range(4))
				0: cp = 16'($urandom_range(16'h007F, 16'h0000));
				1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
				2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
				3: begin
					case ($urandom_range(5))
						0: cp = 16'h0000;
						1: cp = 16'h007F;
						2: cp = 16'h0080;
						3: cp = 16'h07FF;
						4: cp = 16'h0800;
						default: cp = 16'hFFFF;
					endcase
				end
				default: cp = 16'($urandom_range(16'hFFFF, 16'h0000));
			endcase
			send_byte(CH_BSLASH, 1'b0);
			send_byte(CH_U, 1'b0);
			for (int i = 3; i >= 0; i--) begin
				// now and then a digit that is no hex digit
				if ($urandom_range(15) == 0)
					send_byte(8'($urandom_range(255)), 1'b0);
				else
					send_byte(hex_char(cp[4 * i +: 4], 1'($urandom_range(1))), 1'b0);
			end
		end else if (kind < 88) begin
			send_byte(CH_QUOTE, 1'b0);
		end else if (kind < 93) begin
			send_byte(CH_BSLASH, 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
		end else if (kind < 96) begin
			// cut the input short, possibly inside an escape
			k = $urandom_range(5);
			if (k >= 1)
				send_byte(CH_BSLASH, 1'b0);
			if (k >= 2)
				send_byte(CH_U, 1'b0);
			for (int i = 2; i < k; i++)
				send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b1);
		end else begin
			send_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic random_run(input int unsigned count);
		int unsigned goal;
		goal = items_sent + count;
		while (items_sent < goal) send_random_piece();
	endtask

	// Check each taken word against the oldest queued one; pick the next stall
	always @(posedge clk) begin
		word_t got;
		word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_byte, byte_valid, string_end, error_flag, last};
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", got));
			end else begin
				want = pending_words.pop_front();
				if (got.data !== want.data)
					report_mismatch($sformatf("out_byte %h, expected %h", got.data, want.data));
				if (got.data_ok !== want.data_ok)
					report_mismatch($sformatf("byte_valid %b, expected %b", got.data_ok,
						want.data_ok));
				if (got.closed !== want.closed)
					report_mismatch($sformatf("string_end %b, expected %b", got.closed,
						want.closed));
				if (got.broken !== want.broken)
					report_mismatch($sformatf("error_flag %b, expected %b", got.broken,
						want.broken));
				if (got.tail !== want.tail)
					report_mismatch($sformatf("last %b, expected %b", got.tail, want.tail));
			end
			words_checked++;
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, quote, escaped quote, unknown escape
		add_row(8'h00, 1'b0, 1'b1, 1, data_word(8'h00, 1'b1));
		add_row(8'hFF, 1'b0, 1'b1, 1, data_word(8'hFF, 1'b1));
		add_row(CH_QUOTE, 1'b0, 1'b1, 1, W_QUOTE);
		add_row(CH_BSLASH, 1'b0, 1'b1, 0, W_NONE);
		add_row(CH_QUOTE, 1'b0, 1'b1, 1, data_word(CH_QUOTE, 1'b1));
		add_row(CH_BSLASH, 1'b0, 1'b1, 0, W_NONE);
		add_row("z", 1'b0, 1'b1, 0, W_NONE);
		// \u07FF: top two-byte code
		add_row(CH_BSLASH, 1'b0, 1'b1, 0, W_NONE);
		add_row(CH_U, 1'b0, 1'b1, 0, W_NONE);
		add_row("0", 1'b0, 1'b0, 0, W_NONE);
		add_row("7", 1'b0, 1'b0, 0, W_NONE);
		add_row("F", 1'b0, 1'b0, 0, W_NONE);
		add_row("F", 1'b0, 1'b0, 0, W_NONE);
		// \uffg": non-hex digits count as zero, a quote too
		add_row(CH_BSLASH, 1'b0, 1'b1, 0, W_NONE);
		add_row(CH_U, 1'b0, 1'b1, 0, W_NONE);
		add_row("f", 1'b0, 1'b0, 0, W_NONE);
		add_row("f", 1'b0, 1'b0, 0, W_NONE);
		add_row("g", 1'b0, 1'b0, 0, W_NONE);
		add_row(CH_QUOTE, 1'b0, 1'b0, 0, W_NONE);
		// end of input inside \u, then in plain text
		add_row(CH_BSLASH, 1'b0, 1'b1, 0, W_NONE);
		add_row(CH_U, 1'b0, 1'b1, 0, W_NONE);
		add_row("0", 1'b0, 1'b0, 0, W_NONE);
		add_row(8'hA5, 1'b1, 1'b1, 1, W_ERR);
		add_row(8'h5A, 1'b1, 1'b1, 1, W_ERR);

		foreach (directed_bytes[i]) begin
			typed_row = directed_bytes[i].typed;
			typed_words.delete();
			if (directed_bytes[i].n != 0)
				typed_words.insert(typed_words.size(), directed_bytes[i].w);
			send_byte(directed_bytes[i].ch, directed_bytes[i].eos);
		end
		typed_row = 1'b0;

		// random fragments under each idle pattern
		random_run(72);
		drain();
		idle_pct = 49;
		random_run(72);
		drain();
		idle_pct = 0;
		stall_pct = 49;
		random_run(72);
		drain();
		idle_pct = 21;
		stall_pct = 21;
		random_run(72);
		drain();

		repeat (8) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d words never came out", pending_words.size()));
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
